### rtl/rufp_pkg.sv
package rufp_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TAG_W   = 32;
   localparam int unsigned VALUE_W = 56;
   localparam int unsigned STAT_W  = 2;

   localparam logic [BYTE_W-1:0] FRAME_START = 8'h02;
   localparam logic [BYTE_W-1:0] FRAME_END   = 8'h03;
   localparam logic [BYTE_W-1:0] LEN_MIN     = 8'd9;
   localparam logic [BYTE_W-1:0] LEN_MAX     = 8'd10;
   // length byte counts start, length, checksum and end on top of the payload
   localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd4;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_LEN = 2'd1,
      ST_BAD_SUM = 2'd2,
      ST_BAD_END = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_START    = 5'b00001,
      PH_LENGTH   = 5'b00010,
      PH_PAYLOAD  = 5'b00100,
      PH_CHECKSUM = 5'b01000,
      PH_END      = 5'b10000
   } phase_type;

   typedef struct packed {
      logic               produce;
      status_type         status;
      logic [TAG_W-1:0]   tag_id;
      logic [VALUE_W-1:0] frame_value;
      logic               is_new;
   } result_type;

endpackage

### rtl/rufp_parser.sv
module rufp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [rufp_pkg::BYTE_W-1:0] rx_byte,
   output rufp_pkg::result_type      result
);
   import rufp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [2:0]         left_ff, left_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [VALUE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0]  len_less;
   logic [2:0]         left_dec;

   function automatic logic [BYTE_W-1:0] xor_bytes(input logic [VALUE_W-1:0] v);
      logic [BYTE_W-1:0] c;
      c = '0;
      for (int i = 0; i < VALUE_W / BYTE_W; i++) begin
         c = c ^ v[i*BYTE_W +: BYTE_W];
      end
      return c;
   endfunction

   assign len_less = rx_byte - LEN_OVERHEAD;
   assign left_dec = left_ff - 3'd1;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      value_in = value_ff;
      prev_in  = prev_ff;
      result   = '{produce: 1'b0, status: ST_OK, tag_id: '0, frame_value: '0, is_new: 1'b0};
      case (phase_ff)
         PH_LENGTH: begin
            if (rx_byte inside {[LEN_MIN:LEN_MAX]}) begin
               value_in = {{(VALUE_W-BYTE_W){1'b0}}, rx_byte};
               left_in  = len_less[2:0];
               phase_in = PH_PAYLOAD;
            end else begin
               phase_in       = PH_START;
               result.produce = 1'b1;
               result.status  = ST_BAD_LEN;
            end
         end
         PH_PAYLOAD: begin
            value_in = {value_ff[VALUE_W-BYTE_W-1:0], rx_byte};
            left_in  = left_dec;
            if (left_dec == 3'd0) begin
               phase_in = PH_CHECKSUM;
            end
         end
         PH_CHECKSUM: begin
            if (xor_bytes(value_ff) == rx_byte) begin
               phase_in = PH_END;
            end else begin
               phase_in           = PH_START;
               result.produce     = 1'b1;
               result.status      = ST_BAD_SUM;
               result.frame_value = value_ff;
            end
         end
         PH_END: begin
            phase_in           = PH_START;
            result.produce     = 1'b1;
            result.frame_value = value_ff;
            if (rx_byte != FRAME_END) begin
               result.status = ST_BAD_END;
            end else begin
               result.status = ST_OK;
               result.tag_id = value_ff[TAG_W-1:0];
               result.is_new = (value_ff != prev_ff);
               prev_in       = value_ff;
            end
         end
         default: begin
            phase_in = (rx_byte == FRAME_START) ? PH_LENGTH : PH_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         left_ff  <= '0;
         value_ff <= '0;
         prev_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         value_ff <= value_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

### rtl/rfid_uart_frame_parser_core.sv
// Channel   Direction  Ports                                          Beat
// req_      in         req_valid, req_stall, req_rx_byte              one received byte
// rsp_      out        rsp_valid, rsp_stall, rsp_status, rsp_tag_id,  one frame outcome
//                      rsp_frame_value, rsp_is_new
//
// One byte per cycle sustained unless a byte with a result meets a stalled
// result slot; a byte that closes or breaks a frame passes the byte register and
// the parse, and its result is written into the result register.
// The rate is set by the single parse step between the byte register and the
// result register. Reset is synchronous and returns the parser to hunting for a
// start byte with cleared value and previous-frame registers. A stalled result
// holds the result register; bytes that give no result keep flowing past it.
module rfid_uart_frame_parser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rufp_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rufp_pkg::STAT_W-1:0]  rsp_status,
   output logic [rufp_pkg::TAG_W-1:0]   rsp_tag_id,
   output logic [rufp_pkg::VALUE_W-1:0] rsp_frame_value,
   output logic                         rsp_is_new
);
   import rufp_pkg::*;

   // byte register in front of the parser
   logic              hold_valid_ff, hold_valid_in;
   logic [BYTE_W-1:0] hold_byte_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   result_type parse_result;
   logic       out_free;
   logic       advance;
   logic       accept;

   rufp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (hold_byte_ff),
      .result  (parse_result)
   );

   // the held byte moves on unless it has a result and the result slot is taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = hold_valid_ff && (!parse_result.produce || out_free);
   assign req_stall = hold_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && parse_result.produce) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_byte_ff <= req_rx_byte;
      end
      if (advance && parse_result.produce) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_tag_id      = rsp_data_ff.tag_id;
   assign rsp_frame_value = rsp_data_ff.frame_value;
   assign rsp_is_new      = rsp_data_ff.is_new;

endmodule

### rtl/rufp_checker.sv
module rufp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rufp_pkg::STAT_W-1:0]  rsp_status,
   input logic [rufp_pkg::TAG_W-1:0]   rsp_tag_id,
   input logic [rufp_pkg::VALUE_W-1:0] rsp_frame_value,
   input logic                         rsp_is_new
);
   import rufp_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag_id)
         && $stable(rsp_frame_value) && $stable(rsp_is_new))
      else $error("stalled result beat changed");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_tag_id == '0 && !rsp_is_new)
      else $error("error beat carries tag or new flag");

   a_bad_len_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_LEN |-> rsp_frame_value == '0)
      else $error("bad length beat carries a value");

   a_tag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_tag_id == rsp_frame_value[TAG_W-1:0])
      else $error("tag does not match low bits of frame value");

endmodule

bind rfid_uart_frame_parser_core rufp_checker u_rufp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_tag_id      (rsp_tag_id),
   .rsp_frame_value (rsp_frame_value),
   .rsp_is_new      (rsp_is_new)
);

### tb/sv/rfid_frame_checker.sv
`timescale 1ns / 100ps

module rfid_frame_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [rufp_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [rufp_pkg::STAT_W-1:0]  rsp_status,
   input  logic [rufp_pkg::TAG_W-1:0]   rsp_tag_id,
   input  logic [rufp_pkg::VALUE_W-1:0] rsp_frame_value,
   input  logic                         rsp_is_new,
   output int                           fail_count,
   output int                           outcomes_pending,
   output int                           good_frames,
   output int                           error_frames
);
   import rufp_pkg::*;

   typedef struct {
      status_type         status;
      logic [TAG_W-1:0]   tag_id;
      logic [VALUE_W-1:0] frame_value;
      logic               is_new;
   } frame_outcome_type;

   frame_outcome_type  outcome_q[$];
   phase_type          parse_phase;
   logic [2:0]         payload_left;
   logic [VALUE_W-1:0] frame_acc;
   logic [VALUE_W-1:0] last_good_value;
   int                 fails;
   int                 n_good;
   int                 n_err;

   function automatic logic [BYTE_W-1:0] fold_xor(input logic [VALUE_W-1:0] v);
      logic [BYTE_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < VALUE_W / BYTE_W; i++) begin
         acc ^= v[i*BYTE_W +: BYTE_W];
      end
      return acc;
   endfunction

   task automatic queue_outcome(input status_type st, input logic [TAG_W-1:0] tag,
                                input logic [VALUE_W-1:0] val, input logic nw);
      frame_outcome_type o;
      o.status      = st;
      o.tag_id      = tag;
      o.frame_value = val;
      o.is_new      = nw;
      outcome_q.push_back(o);
   endtask

   // one parse step per accepted byte beat
   task automatic parse_byte(input logic [BYTE_W-1:0] b);
      case (parse_phase)
         PH_LENGTH: begin
            if (b >= LEN_MIN && b <= LEN_MAX) begin
               frame_acc    = VALUE_W'(b);
               payload_left = 3'(b - LEN_OVERHEAD);
               parse_phase  = PH_PAYLOAD;
            end else begin
               parse_phase = PH_START;
               queue_outcome(ST_BAD_LEN, '0, '0, 1'b0);
            end
         end
         PH_PAYLOAD: begin
            frame_acc    = {frame_acc[VALUE_W-BYTE_W-1:0], b};
            payload_left = payload_left - 3'd1;
            if (payload_left == 3'd0) parse_phase = PH_CHECKSUM;
         end
         PH_CHECKSUM: begin
            if (fold_xor(frame_acc) == b) begin
               parse_phase = PH_END;
            end else begin
               parse_phase = PH_START;
               queue_outcome(ST_BAD_SUM, '0, frame_acc, 1'b0);
            end
         end
         PH_END: begin
            parse_phase = PH_START;
            if (b != FRAME_END) begin
               queue_outcome(ST_BAD_END, '0, frame_acc, 1'b0);
            end else begin
               queue_outcome(ST_OK, frame_acc[TAG_W-1:0], frame_acc,
                             frame_acc != last_good_value);
               last_good_value = frame_acc;
            end
         end
         default: begin
            parse_phase = (b == FRAME_START) ? PH_LENGTH : PH_START;
         end
      endcase
   endtask

   task automatic note_fail(input string what);
      fails++;
      if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic check_outcome();
      frame_outcome_type o;
      if (outcome_q.size() == 0) begin
         note_fail($sformatf("unexpected result st=%0d tag=%h val=%h new=%b",
                             rsp_status, rsp_tag_id, rsp_frame_value, rsp_is_new));
         return;
      end
      o = outcome_q.pop_front();
      if (rsp_status !== o.status)
         note_fail($sformatf("status exp %0d got %0d", o.status, rsp_status));
      else if (o.status == ST_OK) n_good++;
      else n_err++;
      if (rsp_tag_id !== o.tag_id)
         note_fail($sformatf("tag_id exp %h got %h", o.tag_id, rsp_tag_id));
      if (rsp_frame_value !== o.frame_value)
         note_fail($sformatf("frame_value exp %h got %h", o.frame_value, rsp_frame_value));
      if (rsp_is_new !== o.is_new)
         note_fail($sformatf("is_new exp %b got %b", o.is_new, rsp_is_new));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         outcome_q.delete();
         parse_phase     = PH_START;
         payload_left    = '0;
         frame_acc       = '0;
         last_good_value = '0;
         fails           = 0;
         n_good          = 0;
         n_err           = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_outcome();
         if (req_valid === 1'b1 && req_stall === 1'b0) parse_byte(req_rx_byte);
      end
      fail_count       <= fails;
      outcomes_pending <= outcome_q.size();
      good_frames      <= n_good;
      error_frames     <= n_err;
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rufp_pkg::*;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // byte channel into the parser
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_rx_byte = '0;

   // outcome channel out of the parser
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [STAT_W-1:0]  rsp_status;
   logic [TAG_W-1:0]   rsp_tag_id;
   logic [VALUE_W-1:0] rsp_frame_value;
   logic               rsp_is_new;

   // results from the checker
   int fail_count;
   int outcomes_pending;
   int good_frames;
   int error_frames;

   // pacing knobs, percent of cycles
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int bytes_sent    = 0;

   // frame under construction; only the first len-4 entries are sent
   logic [BYTE_W-1:0] body      [0:5];
   logic [BYTE_W-1:0] last_body [0:5];
   logic [BYTE_W-1:0] last_len;
   bit                have_good = 1'b0;

   always #6 clock = ~clock;

   rfid_uart_frame_parser_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_tag_id      (rsp_tag_id),
      .rsp_frame_value (rsp_frame_value),
      .rsp_is_new      (rsp_is_new)
   );

   rfid_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tag_id       (rsp_tag_id),
      .rsp_frame_value  (rsp_frame_value),
      .rsp_is_new       (rsp_is_new),
      .fail_count       (fail_count),
      .outcomes_pending (outcomes_pending),
      .good_frames      (good_frames),
      .error_frames     (error_frames)
   );

   // Receiver back-pressure: redrawn every cycle, one NBA per edge.
   // Held low through reset so the first beats see a free channel.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // Biased byte source: the two rails turn up often so every bit
   // sees both levels well inside the run.
   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one byte beat and hold it until taken. Random gaps go in
   // before the beat; valid is only raised once the gap is done, and
   // the payload never moves while the beat is stalled.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   // Whole frame from body[]: start, length, payload, check byte (XOR
   // of length and payload, optionally spoilt by chk_flip), then tail.
   task automatic send_frame(input logic [BYTE_W-1:0] len,
                             input logic [BYTE_W-1:0] chk_flip,
                             input logic [BYTE_W-1:0] tail);
      logic [BYTE_W-1:0] chk;
      chk = len;
      send_byte(FRAME_START);
      send_byte(len);
      for (int i = 0; i < int'(len - LEN_OVERHEAD); i++) begin
         chk ^= body[i];
         send_byte(body[i]);
      end
      send_byte(chk ^ chk_flip);
      send_byte(tail);
   endtask

   // One randomly chosen sequence. Mostly well-formed frames so the
   // parser spends its time deep in payload and trailer states; the
   // rest are broken frames and line noise.
   task automatic send_random_sequence();
      int                kind;
      logic [BYTE_W-1:0] len;
      logic [BYTE_W-1:0] b;
      kind = $urandom_range(99);
      len  = $urandom_range(1) ? LEN_MAX : LEN_MIN;
      if (have_good && $urandom_range(4) == 0) begin
         // resend the last good frame so is_new drops
         len = last_len;
         for (int i = 0; i < 6; i++) body[i] = last_body[i];
      end else begin
         for (int i = 0; i < 6; i++) body[i] = pick_byte();
      end
      if (kind < 55) begin
         send_frame(len, '0, FRAME_END);
         last_len  = len;
         last_body = body;
         have_good = 1'b1;
      end else if (kind < 65) begin
         // start then a length byte out of range
         do b = pick_byte(); while (b == LEN_MIN || b == LEN_MAX);
         send_byte(FRAME_START);
         send_byte(b);
      end else if (kind < 75) begin
         send_frame(len, BYTE_W'($urandom_range(1, 255)), FRAME_END);
      end else if (kind < 85) begin
         // wrong trailer; a start code here must not open a new frame
         b = pick_byte();
         if (b == FRAME_END || $urandom_range(3) == 0) b = FRAME_START;
         send_frame(len, '0, b);
      end else begin
         // noise, sometimes with stray start codes that truncate frames
         repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end
   endtask

   // Stimulus: reset, directed frames, then three pacing phases.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct  = 29;
      rsp_stall_pct = 65;

      // skipped byte while hunting, then a length byte just below range
      send_byte(8'h00);
      send_byte(FRAME_START);
      send_byte(8'h08);
      // longest frame, payload all ones
      for (int i = 0; i < 6; i++) body[i] = 8'hFF;
      send_frame(LEN_MAX, '0, FRAME_END);
      // shortest frame, payload all zeros, trailer is a start code
      for (int i = 0; i < 6; i++) body[i] = 8'h00;
      send_frame(LEN_MIN, '0, FRAME_START);

      while (bytes_sent < 283) send_random_sequence();
      send_gap_pct  = 65;
      rsp_stall_pct = 29;
      while (bytes_sent < 566) send_random_sequence();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      while (bytes_sent < 850) send_random_sequence();
      req_valid <= 1'b0;

      // drain: an outcome lands once its byte has passed the byte and result registers
      @(posedge clock);
      while (outcomes_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes across three pacing mixes; checked %0d good frames",
               bytes_sent, good_frames);
      $display("and %0d error outcomes (length, check byte, trailer).", error_frames);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
rtl/rufp_pkg.sv
rtl/rufp_parser.sv
rtl/rfid_uart_frame_parser_core.sv
rtl/rufp_checker.sv
tb/sv/rfid_frame_checker.sv
tb/sv/tb_top.sv
